### design/aeps_pkg.sv
`default_nettype none

package aeps_pkg;

  localparam int MAX_LEVELS_DEF  = 8;
  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int ID_BITS_DEF     = 8;

  localparam int REQ_W    = 2;
  localparam int PRIO_W   = 3;
  localparam int STATIC_W = 4;
  localparam int STATUS_W = 3;
  localparam int NLVL_W   = 4;

  localparam logic [NLVL_W-1:0] NUM_LEVELS_RST = 4'd4;

  // only the upper request bit selects dispatch
  localparam logic [REQ_W-1:0] REQ_PLAIN = 2'd0;
  localparam logic [REQ_W-1:0] REQ_DECAY = 2'd1;
  localparam int               REQ_DISPATCH_BIT = 1;

  typedef enum logic [STATUS_W-1:0] {
    ST_ADDED      = 3'd0,
    ST_DISPATCHED = 3'd1,
    ST_NONE       = 3'd2,
    ST_FULL       = 3'd3,
    ST_RANGE      = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADD,
    S_SCAN,
    S_READ,
    S_DONE
  } state_e;

endpackage

`default_nettype wire

### design/aeps_ifs.sv
`default_nettype none

interface aeps_req_if
  import aeps_pkg::*;
#(
  parameter int ID_W = ID_BITS_DEF
);
  logic                valid;
  logic                ready;
  logic [REQ_W-1:0]    req_type;
  logic [ID_W-1:0]     process_id;
  logic [PRIO_W-1:0]   dyn_prio;
  logic [STATIC_W-1:0] static_prio;

  modport source (output valid, output req_type, output process_id, output dyn_prio,
                  output static_prio, input ready);
  modport sink   (input valid, input req_type, input process_id, input dyn_prio,
                  input static_prio, output ready);
endinterface

interface aeps_rsp_if
  import aeps_pkg::*;
#(
  parameter int ID_W = ID_BITS_DEF
);
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [ID_W-1:0]     out_id;
  logic [PRIO_W-1:0]   out_level;
  logic [PRIO_W-1:0]   new_dyn_prio;
  logic                to_expired;

  modport source (output valid, output status, output out_id, output out_level,
                  output new_dyn_prio, output to_expired, input ready);
  modport sink   (input valid, input status, input out_id, input out_level,
                  input new_dyn_prio, input to_expired, output ready);
endinterface

`default_nettype wire

### design/aeps_ram.sv
`default_nettype none

module aeps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    addr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_o <= mem[addr_i];
  end

endmodule

`default_nettype wire

### design/active_expired_priority_scheduler_core.sv
`default_nettype none

// Two banks (active, expired) of FIFO ready queues, one queue per priority
// level, all held in one single-port RAM with head, tail and fill count per
// queue in flip-flops. Requests are handled one at a time. An add (plain or
// decay) goes through the add and done states before the next transfer. A dispatch
// walks the active bank from the top level down, one level per clock through
// the shared count/pointer lookup, then reads the queue RAM (registered read).
// An empty active bank makes the banks swap once and the walk start again;
// both banks empty end it with no dispatch. The level count is num_levels, with 0
// taken as 1 and clipped to MAX_LEVELS. A finished result sits in an output register,
// so a new request is taken while it waits. The queue RAM is not cleared at
// reset; an entry is only read after it was written.
module active_expired_priority_scheduler_core
  import aeps_pkg::*;
#(
  parameter int MAX_LEVELS  = MAX_LEVELS_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int ID_BITS     = ID_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  aeps_req_if.sink          req_i,
  aeps_rsp_if.source        rsp_o,
  input  logic              cfg_we_i,
  input  logic [NLVL_W-1:0] cfg_wdata_i
);

  localparam int NUM_Q     = 2 * MAX_LEVELS;
  localparam int Q_W       = $clog2(NUM_Q);
  localparam int LVL_W     = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
  localparam int LC_W      = $clog2(MAX_LEVELS + 1);
  localparam int PTR_W     = $clog2(QUEUE_DEPTH);
  localparam int CNT_W     = $clog2(QUEUE_DEPTH + 1);
  localparam int RAM_DEPTH = NUM_Q * QUEUE_DEPTH;
  localparam int ADDR_W    = $clog2(RAM_DEPTH);

  function automatic logic [Q_W-1:0] qidx(input logic bank, input logic [LVL_W-1:0] lvl);
    qidx = bank ? Q_W'(MAX_LEVELS + int'(lvl)) : Q_W'(lvl);
  endfunction

  function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
    next_ptr = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  state_e state_q, state_d;

  logic [NLVL_W-1:0]   num_levels_q;
  logic                active_bank_q;
  logic [LVL_W-1:0]    idx_q;
  logic                swapped_q;

  logic [PTR_W-1:0]    head_q [NUM_Q];
  logic [PTR_W-1:0]    tail_q [NUM_Q];
  logic [CNT_W-1:0]    cnt_q  [NUM_Q];

  logic [REQ_W-1:0]    req_type_q;
  logic [ID_BITS-1:0]  pid_q;
  logic [PRIO_W-1:0]   dyn_q;
  logic [STATIC_W-1:0] stat_q;

  status_e             res_status_q;
  logic [ID_BITS-1:0]  res_id_q;
  logic [PRIO_W-1:0]   res_lvl_q;
  logic [PRIO_W-1:0]   res_ndyn_q;
  logic                res_exp_q;

  logic                rsp_valid_q;
  status_e             rsp_status_q;
  logic [ID_BITS-1:0]  rsp_id_q;
  logic [PRIO_W-1:0]   rsp_lvl_q;
  logic [PRIO_W-1:0]   rsp_ndyn_q;
  logic                rsp_exp_q;

  logic [LC_W-1:0]     lc;
  logic [LVL_W-1:0]    lc_m1;

  logic                is_decay;
  logic                wrap;
  logic [STATIC_W-1:0] tgt;
  logic                add_bad;
  logic                add_bank;
  logic [LVL_W-1:0]    add_lvl;

  logic [Q_W-1:0]      q_sel;
  logic [CNT_W-1:0]    cnt_sel;
  logic [PTR_W-1:0]    head_sel;
  logic [PTR_W-1:0]    tail_sel;
  logic [PTR_W-1:0]    ptr_sel;
  logic                full;
  logic                hit;
  logic [ADDR_W-1:0]   ram_addr;
  logic [ID_BITS-1:0]  ram_rdata;

  logic                req_ready;
  logic                req_acc;
  logic                push;
  logic                pop;
  logic                scan_wrap;
  logic                scan_step;
  logic                scan_none;
  logic                rsp_load;

  // effective level count: 0 acts as 1, clipped to the built maximum
  always_comb begin
    if (num_levels_q == '0) begin
      lc = LC_W'(1);
    end else if (int'(num_levels_q) > MAX_LEVELS) begin
      lc = LC_W'(MAX_LEVELS);
    end else begin
      lc = LC_W'(num_levels_q);
    end
  end
  assign lc_m1 = LVL_W'(lc - LC_W'(1));

  // add target
  assign is_decay = (req_type_q == REQ_DECAY);
  assign wrap     = is_decay && (dyn_q == '0);

  always_comb begin
    priority if (wrap) begin
      tgt = stat_q - 1'b1;
    end else if (is_decay) begin
      tgt = STATIC_W'(PRIO_W'(dyn_q - 1'b1));
    end else begin
      tgt = STATIC_W'(dyn_q);
    end
  end

  assign add_bad  = (wrap && (stat_q == '0)) || (int'(tgt) >= int'(lc));
  assign add_bank = active_bank_q ^ wrap;
  assign add_lvl  = LVL_W'(tgt);

  // shared queue lookup
  assign q_sel    = (state_q == S_ADD) ? qidx(add_bank, add_lvl) : qidx(active_bank_q, idx_q);
  assign cnt_sel  = cnt_q[q_sel];
  assign head_sel = head_q[q_sel];
  assign tail_sel = tail_q[q_sel];
  assign full     = (cnt_sel == CNT_W'(QUEUE_DEPTH));
  assign hit      = (cnt_sel != '0);
  assign ptr_sel  = (state_q == S_ADD) ? tail_sel : head_sel;
  assign ram_addr = ADDR_W'(int'(q_sel) * QUEUE_DEPTH + int'(ptr_sel));

  aeps_ram #(
    .WIDTH (ID_BITS),
    .DEPTH (RAM_DEPTH)
  ) u_aeps_ram (
    .clk_i   (clk_i),
    .we_i    (push),
    .addr_i  (ram_addr),
    .wdata_i (pid_q),
    .rdata_o (ram_rdata)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (req_acc) begin
          state_d = req_i.req_type[REQ_DISPATCH_BIT] ? S_SCAN : S_ADD;
        end
      end
      S_ADD: begin
        state_d = S_DONE;
      end
      S_SCAN: begin
        if (hit) begin
          state_d = S_READ;
        end else if (swapped_q && (idx_q == '0)) begin
          state_d = S_DONE;
        end
      end
      S_READ: begin
        state_d = S_DONE;
      end
      S_DONE: begin
        if (rsp_load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control
  always_comb begin
    req_ready = (state_q == S_IDLE);
    req_acc   = req_i.valid && req_ready;
    push      = (state_q == S_ADD) && !add_bad && !full;
    pop       = (state_q == S_SCAN) && hit;
    scan_step = (state_q == S_SCAN) && !hit && (idx_q != '0);
    scan_wrap = (state_q == S_SCAN) && !hit && (idx_q == '0) && !swapped_q;
    scan_none = (state_q == S_SCAN) && !hit && (idx_q == '0) && swapped_q;
    rsp_load  = (state_q == S_DONE) && (!rsp_valid_q || rsp_o.ready);
  end

  assign req_i.ready = req_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      num_levels_q  <= NUM_LEVELS_RST;
      active_bank_q <= 1'b0;
      idx_q         <= '0;
      swapped_q     <= 1'b0;
      rsp_valid_q   <= 1'b0;
      for (int i = 0; i < NUM_Q; i++) begin
        head_q[i] <= '0;
        tail_q[i] <= '0;
        cnt_q[i]  <= '0;
      end
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        num_levels_q <= cfg_wdata_i;
      end
      if (req_acc) begin
        idx_q     <= lc_m1;
        swapped_q <= 1'b0;
      end
      if (scan_step) begin
        idx_q <= idx_q - 1'b1;
      end
      // whole active bank empty: swap once and rescan
      if (scan_wrap) begin
        active_bank_q <= ~active_bank_q;
        swapped_q     <= 1'b1;
        idx_q         <= lc_m1;
      end
      if (push) begin
        tail_q[q_sel] <= next_ptr(tail_sel);
        cnt_q[q_sel]  <= cnt_sel + 1'b1;
      end
      if (pop) begin
        head_q[q_sel] <= next_ptr(head_sel);
        cnt_q[q_sel]  <= cnt_sel - 1'b1;
      end
      if (rsp_load) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_acc) begin
      req_type_q <= req_i.req_type;
      pid_q      <= req_i.process_id;
      dyn_q      <= req_i.dyn_prio;
      stat_q     <= req_i.static_prio;
    end

    if (state_q == S_ADD) begin
      res_id_q <= '0;
      if (add_bad) begin
        res_status_q <= ST_RANGE;
        res_lvl_q    <= '0;
        res_ndyn_q   <= dyn_q;
        res_exp_q    <= 1'b0;
      end else if (full) begin
        res_status_q <= ST_FULL;
        res_lvl_q    <= '0;
        res_ndyn_q   <= dyn_q;
        res_exp_q    <= 1'b0;
      end else begin
        res_status_q <= ST_ADDED;
        res_lvl_q    <= PRIO_W'(tgt);
        res_ndyn_q   <= PRIO_W'(tgt);
        res_exp_q    <= wrap;
      end
    end

    if (pop) begin
      res_status_q <= ST_DISPATCHED;
      res_lvl_q    <= PRIO_W'(idx_q);
      res_ndyn_q   <= '0;
      res_exp_q    <= 1'b0;
    end
    if (scan_none) begin
      res_status_q <= ST_NONE;
      res_id_q     <= '0;
      res_lvl_q    <= '0;
      res_ndyn_q   <= '0;
      res_exp_q    <= 1'b0;
    end
    // RAM data for the popped entry is valid in S_READ, after the registered read
    if (state_q == S_READ) begin
      res_id_q <= ram_rdata;
    end

    if (rsp_load) begin
      rsp_status_q <= res_status_q;
      rsp_id_q     <= res_id_q;
      rsp_lvl_q    <= res_lvl_q;
      rsp_ndyn_q   <= res_ndyn_q;
      rsp_exp_q    <= res_exp_q;
    end
  end

  assign rsp_o.valid        = rsp_valid_q;
  assign rsp_o.status       = rsp_status_q;
  assign rsp_o.out_id       = rsp_id_q;
  assign rsp_o.out_level    = rsp_lvl_q;
  assign rsp_o.new_dyn_prio = rsp_ndyn_q;
  assign rsp_o.to_expired   = rsp_exp_q;

endmodule

`default_nettype wire

### design/aeps_checker.sv
`default_nettype none

module aeps_checker
  import aeps_pkg::*;
#(
  parameter int ID_W = ID_BITS_DEF
) (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                req_valid_i,
  input logic                req_ready_i,
  input logic                rsp_valid_i,
  input logic                rsp_ready_i,
  input logic [STATUS_W-1:0] rsp_status_i,
  input logic [ID_W-1:0]     rsp_out_id_i,
  input logic [PRIO_W-1:0]   rsp_out_level_i,
  input logic [PRIO_W-1:0]   rsp_new_dyn_prio_i,
  input logic                rsp_to_expired_i
);

  // one request at a time: busy right after a transfer
  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("request taken while previous one in flight");

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_status_i) &&
      $stable(rsp_out_id_i) && $stable(rsp_out_level_i) &&
      $stable(rsp_new_dyn_prio_i) && $stable(rsp_to_expired_i))
    else $error("stalled response changed");

  a_id_only_dispatch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (rsp_status_i != ST_DISPATCHED) |-> rsp_out_id_i == '0)
    else $error("nonzero id without dispatch");

  a_flag_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (rsp_status_i == ST_NONE || rsp_status_i == ST_FULL ||
      rsp_status_i == ST_RANGE) |-> (rsp_out_level_i == '0) && !rsp_to_expired_i)
    else $error("flagged response carries level or expired mark");

  a_add_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (rsp_status_i == ST_ADDED) |-> rsp_out_level_i == rsp_new_dyn_prio_i)
    else $error("add level and new priority differ");

endmodule

bind active_expired_priority_scheduler_core aeps_checker #(
  .ID_W (ID_BITS)
) u_aeps_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .req_valid_i        (req_i.valid),
  .req_ready_i        (req_i.ready),
  .rsp_valid_i        (rsp_o.valid),
  .rsp_ready_i        (rsp_o.ready),
  .rsp_status_i       (rsp_o.status),
  .rsp_out_id_i       (rsp_o.out_id),
  .rsp_out_level_i    (rsp_o.out_level),
  .rsp_new_dyn_prio_i (rsp_o.new_dyn_prio),
  .rsp_to_expired_i   (rsp_o.to_expired)
);

`default_nettype wire
